// ===== design/tlr_pkg.sv =====
`timescale 1ns / 1ps

package tlr_pkg;

    // Logical drawing area.
    localparam int LOGICAL_WIDTH  = 320;
    localparam int LOGICAL_HEIGHT = 116;

    // Field widths.
    localparam int COORD_W  = 11;
    localparam int COLOR_W  = 24;
    localparam int BRUSH_W  = 5;
    localparam int CW_W     = 9;
    localparam int CH_W     = 7;
    localparam int SPAN_W   = 12;
    localparam int ERR_W    = 14;
    localparam int INK_W    = 16;
    localparam int ADDR_W   = 16;
    localparam int POS_W    = 13;

    // Stream packing.
    localparam int S_TDATA_W   = 80;
    localparam int SX_LSB      = 0;
    localparam int SY_LSB      = 11;
    localparam int EX_LSB      = 22;
    localparam int EY_LSB      = 33;
    localparam int COLOR_LSB   = 44;
    localparam int BRUSH_LSB   = 68;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 2;
    localparam int TUSER_VALID = 0;
    localparam int TUSER_IDLE  = 1;

    // Commands carried in the input tuser bit.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_CANVAS_WIDTH  = 1'b0;
    localparam logic CFG_CANVAS_HEIGHT = 1'b1;
    localparam logic [CW_W-1:0] CANVAS_WIDTH_RESET  = 9'd320;
    localparam logic [CH_W-1:0] CANVAS_HEIGHT_RESET = 7'd116;

    // Scaling: pixel coordinate times canvas size, then divided by the
    // logical size through a rounded-up reciprocal. The shift is chosen so
    // that product * divisor stays below 2**shift, which makes it exact.
    localparam int XPIX_W  = $clog2(LOGICAL_WIDTH);
    localparam int YPIX_W  = $clog2(LOGICAL_HEIGHT);
    localparam int XPROD_W = XPIX_W + CW_W;
    localparam int YPROD_W = YPIX_W + CH_W;
    localparam int SX_SHIFT = XPROD_W + $clog2(LOGICAL_WIDTH);
    localparam int SY_SHIFT = YPROD_W + $clog2(LOGICAL_HEIGHT);
    localparam int RX_W = SX_SHIFT - $clog2(LOGICAL_WIDTH) + 2;
    localparam int RY_W = SY_SHIFT - $clog2(LOGICAL_HEIGHT) + 2;
    localparam longint RX_L = ((64'd1 << SX_SHIFT) + LOGICAL_WIDTH - 1) / LOGICAL_WIDTH;
    localparam longint RY_L = ((64'd1 << SY_SHIFT) + LOGICAL_HEIGHT - 1) / LOGICAL_HEIGHT;
    localparam logic [RX_W-1:0] RECIP_X = RX_W'(RX_L);
    localparam logic [RY_W-1:0] RECIP_Y = RY_W'(RY_L);

    typedef struct packed {
        logic load;
        logic capture;
        logic prod;
        logic recip;
        logic emit;
    } tlr_cmd_t;

    typedef struct packed {
        logic out_busy;
    } tlr_status_t;

endpackage

// ===== design/tlr_ctrl.sv =====
`timescale 1ns / 1ps

module tlr_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tuser,
    output logic                 s_axis_tready,
    input  tlr_pkg::tlr_status_t status,
    output tlr_pkg::tlr_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROD  = 2'd1;
    localparam logic [1:0] ST_RECIP = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == tlr_pkg::CMD_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_PROD;
                    end
                end
            end
            ST_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = ST_RECIP;
            end
            ST_RECIP:
            begin
                cmd.recip  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Hold the finished item until the output register frees up.
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/tlr_datapath.sv =====
`timescale 1ns / 1ps

module tlr_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [tlr_pkg::CW_W-1:0]            cfg_data,
    input  logic [tlr_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    input  tlr_pkg::tlr_cmd_t                   cmd,
    output tlr_pkg::tlr_status_t                status,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [tlr_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    output logic [tlr_pkg::M_TUSER_W-1:0]       m_axis_tuser,
    output logic                                m_axis_tlast
);

    // Configuration.
    logic [tlr_pkg::CW_W-1:0] canvas_w_reg;
    logic [tlr_pkg::CH_W-1:0] canvas_h_reg;

    // Line state.
    logic                              active_reg;
    logic signed [tlr_pkg::COORD_W-1:0] cur_x_reg, cur_y_reg, goal_x_reg, goal_y_reg;
    logic signed [tlr_pkg::COORD_W-1:0] cur_x_next, cur_y_next;
    logic                              step_neg_x_reg, step_neg_y_reg;
    logic [tlr_pkg::SPAN_W-1:0]        span_x_reg, span_y_reg;
    logic signed [tlr_pkg::ERR_W-1:0]  err_reg, err_next;
    logic [tlr_pkg::BRUSH_W-1:0]       brush_dx_reg, brush_dy_reg, brush_size_reg;
    logic [tlr_pkg::BRUSH_W-1:0]       brush_dx_next, brush_dy_next;
    logic                              active_next;
    logic [tlr_pkg::INK_W-1:0]         ink_reg;

    // Pipeline of one step.
    logic                              inside_reg, idle_p_reg, done_p_reg;
    logic [tlr_pkg::INK_W-1:0]         value_p_reg;
    logic [tlr_pkg::XPIX_W-1:0]        xpix_reg;
    logic [tlr_pkg::YPIX_W-1:0]        ypix_reg;
    logic [tlr_pkg::XPROD_W-1:0]       xprod_reg;
    logic [tlr_pkg::YPROD_W-1:0]       yprod_reg;
    logic [tlr_pkg::CW_W-1:0]          px_reg;
    logic [tlr_pkg::CH_W-1:0]          py_reg;

    // Output register.
    logic                              out_valid_reg;
    logic [tlr_pkg::M_TDATA_W-1:0]     out_data_reg;
    logic [tlr_pkg::M_TUSER_W-1:0]     out_user_reg;
    logic                              out_last_reg;

    // Load decode.
    logic signed [tlr_pkg::COORD_W-1:0] ld_x1, ld_y1, ld_x2, ld_y2;
    logic signed [tlr_pkg::SPAN_W-1:0]  diff_x, diff_y;
    logic [tlr_pkg::SPAN_W-1:0]         abs_x, abs_y;
    logic [tlr_pkg::COLOR_W-1:0]        ld_rgb;

    assign ld_x1  = s_axis_tdata[tlr_pkg::SX_LSB +: tlr_pkg::COORD_W];
    assign ld_y1  = s_axis_tdata[tlr_pkg::SY_LSB +: tlr_pkg::COORD_W];
    assign ld_x2  = s_axis_tdata[tlr_pkg::EX_LSB +: tlr_pkg::COORD_W];
    assign ld_y2  = s_axis_tdata[tlr_pkg::EY_LSB +: tlr_pkg::COORD_W];
    assign ld_rgb = s_axis_tdata[tlr_pkg::COLOR_LSB +: tlr_pkg::COLOR_W];
    assign diff_x = {ld_x2[tlr_pkg::COORD_W-1], ld_x2} - {ld_x1[tlr_pkg::COORD_W-1], ld_x1};
    assign diff_y = {ld_y2[tlr_pkg::COORD_W-1], ld_y2} - {ld_y1[tlr_pkg::COORD_W-1], ld_y1};
    assign abs_x  = diff_x[tlr_pkg::SPAN_W-1] ? tlr_pkg::SPAN_W'(-diff_x) : diff_x;
    assign abs_y  = diff_y[tlr_pkg::SPAN_W-1] ? tlr_pkg::SPAN_W'(-diff_y) : diff_y;

    // Brush pixel position and walk.
    logic [3:0]                        brush_low;
    logic signed [tlr_pkg::POS_W-1:0]  pos_x, pos_y;
    logic                              pos_inside, last_brush, at_goal;
    logic signed [15:0]                twice, neg_sy, sx16, err16;
    logic                              move_x, move_y;

    assign brush_low = brush_size_reg[tlr_pkg::BRUSH_W-1:1];
    assign pos_x = tlr_pkg::POS_W'(cur_x_reg) - $signed({9'd0, brush_low})
                 + $signed({8'd0, brush_dx_reg});
    assign pos_y = tlr_pkg::POS_W'(cur_y_reg) - $signed({9'd0, brush_low})
                 + $signed({8'd0, brush_dy_reg});
    assign pos_inside = (brush_size_reg != '0)
                     && (pos_x >= 0) && (pos_x < tlr_pkg::POS_W'(tlr_pkg::LOGICAL_WIDTH))
                     && (pos_y >= 0) && (pos_y < tlr_pkg::POS_W'(tlr_pkg::LOGICAL_HEIGHT));
    assign last_brush = (brush_size_reg == '0)
                     || ((brush_dx_reg == brush_size_reg - 5'd1)
                         && (brush_dy_reg == brush_size_reg - 5'd1));
    assign at_goal = (cur_x_reg == goal_x_reg) && (cur_y_reg == goal_y_reg);

    assign err16  = 16'(err_reg);
    assign twice  = err16 <<< 1;
    assign neg_sy = -$signed({4'd0, span_y_reg});
    assign sx16   = $signed({4'd0, span_x_reg});
    assign move_x = (twice >= neg_sy);
    assign move_y = (twice <= sx16);

    always_comb
    begin
        brush_dx_next = brush_dx_reg;
        brush_dy_next = brush_dy_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        err_next      = err_reg;
        active_next   = active_reg;
        if (!last_brush)
        begin
            if (brush_dx_reg == brush_size_reg - 5'd1)
            begin
                brush_dx_next = '0;
                brush_dy_next = brush_dy_reg + 5'd1;
            end
            else
            begin
                brush_dx_next = brush_dx_reg + 5'd1;
            end
        end
        else
        begin
            brush_dx_next = '0;
            brush_dy_next = '0;
            if (at_goal)
            begin
                active_next = 1'b0;
            end
            else
            begin
                err_next = tlr_pkg::ERR_W'(err16 + (move_x ? neg_sy : 16'sd0)
                                                 + (move_y ? sx16 : 16'sd0));
                if (move_x)
                begin
                    cur_x_next = step_neg_x_reg ? cur_x_reg - 11'sd1 : cur_x_reg + 11'sd1;
                end
                if (move_y)
                begin
                    cur_y_next = step_neg_y_reg ? cur_y_reg - 11'sd1 : cur_y_reg + 11'sd1;
                end
            end
        end
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_w_reg   <= tlr_pkg::CANVAS_WIDTH_RESET;
            canvas_h_reg   <= tlr_pkg::CANVAS_HEIGHT_RESET;
            active_reg     <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            goal_x_reg     <= '0;
            goal_y_reg     <= '0;
            step_neg_x_reg <= 1'b0;
            step_neg_y_reg <= 1'b0;
            span_x_reg     <= '0;
            span_y_reg     <= '0;
            err_reg        <= '0;
            brush_dx_reg   <= '0;
            brush_dy_reg   <= '0;
            brush_size_reg <= '0;
            ink_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == tlr_pkg::CFG_CANVAS_WIDTH)
                begin
                    canvas_w_reg <= cfg_data;
                end
                else
                begin
                    canvas_h_reg <= cfg_data[tlr_pkg::CH_W-1:0];
                end
            end

            if (cmd.load)
            begin
                cur_x_reg      <= ld_x1;
                cur_y_reg      <= ld_y1;
                goal_x_reg     <= ld_x2;
                goal_y_reg     <= ld_y2;
                step_neg_x_reg <= !(ld_x1 < ld_x2);
                step_neg_y_reg <= !(ld_y1 < ld_y2);
                span_x_reg     <= abs_x;
                span_y_reg     <= abs_y;
                err_reg        <= tlr_pkg::ERR_W'($signed({2'd0, abs_x})
                                                - $signed({2'd0, abs_y}));
                ink_reg        <= {ld_rgb[23:19], ld_rgb[15:10], ld_rgb[7:3]};
                brush_size_reg <= s_axis_tdata[tlr_pkg::BRUSH_LSB +: tlr_pkg::BRUSH_W];
                brush_dx_reg   <= '0;
                brush_dy_reg   <= '0;
                active_reg     <= 1'b1;
            end
            else if (cmd.capture && active_reg)
            begin
                brush_dx_reg <= brush_dx_next;
                brush_dy_reg <= brush_dy_next;
                cur_x_reg    <= cur_x_next;
                cur_y_reg    <= cur_y_next;
                err_reg      <= err_next;
                active_reg   <= active_next;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Scaling pipeline and output payload.
    logic [tlr_pkg::XPROD_W+tlr_pkg::RX_W-1:0] xq_full;
    logic [tlr_pkg::YPROD_W+tlr_pkg::RY_W-1:0] yq_full;
    logic [tlr_pkg::CH_W+tlr_pkg::CW_W:0]      addr_full;

    assign xq_full   = xprod_reg * tlr_pkg::RECIP_X;
    assign yq_full   = yprod_reg * tlr_pkg::RECIP_Y;
    assign addr_full = {{(tlr_pkg::CW_W+1){1'b0}}, py_reg}
                     * {{(tlr_pkg::CH_W+1){1'b0}}, canvas_w_reg}
                     + {{(tlr_pkg::CH_W+1){1'b0}}, px_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idle_p_reg  <= !active_reg;
            inside_reg  <= active_reg && pos_inside;
            done_p_reg  <= active_reg && last_brush && at_goal;
            value_p_reg <= active_reg ? ink_reg : '0;
            xpix_reg    <= pos_x[tlr_pkg::XPIX_W-1:0];
            ypix_reg    <= pos_y[tlr_pkg::YPIX_W-1:0];
        end
        if (cmd.prod)
        begin
            xprod_reg <= xpix_reg * canvas_w_reg;
            yprod_reg <= ypix_reg * canvas_h_reg;
        end
        if (cmd.recip)
        begin
            px_reg <= xq_full[tlr_pkg::SX_SHIFT +: tlr_pkg::CW_W];
            py_reg <= yq_full[tlr_pkg::SY_SHIFT +: tlr_pkg::CH_W];
        end
        if (cmd.emit)
        begin
            out_data_reg <= {value_p_reg,
                             inside_reg ? addr_full[tlr_pkg::ADDR_W-1:0] : 16'd0};
            out_user_reg <= {idle_p_reg, inside_reg};
            out_last_reg <= done_p_reg;
        end
    end

    assign status.out_busy = out_valid_reg && !m_axis_tready;
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser    = out_user_reg;
    assign m_axis_tlast    = out_last_reg;

endmodule

// ===== design/thick_line_rasterizer_top.sv =====
`timescale 1ns / 1ps
// A load item gives no result; the next item is taken in the following cycle.
// A step item goes through capture, coordinate-times-canvas multiply, reciprocal multiply,
// then the row-stride multiply-add into the output register, which waits while it is held;
// the engine takes no new item until the step item has been through all of these.
// Reset is asynchronous and active low: no line active, canvas 320 x 116, output empty.

module thick_line_rasterizer_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [tlr_pkg::CW_W-1:0]            cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // start_x[10:0], start_y[21:11], end_x[32:22], end_y[43:33],
    // color_rgb[67:44], brush_width[72:68], zero pad[79:73]
    input  logic [tlr_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // cmd[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pixel_address[15:0], pixel_value[31:16]
    output logic [tlr_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // write_valid[0], idle_step[1]
    output logic [tlr_pkg::M_TUSER_W-1:0]       m_axis_tuser,
    // line_done
    output logic                                m_axis_tlast
);

    tlr_pkg::tlr_cmd_t    cmd;
    tlr_pkg::tlr_status_t status;

    tlr_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    tlr_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== test/thick_line_rasterizer_top_tb.sv =====
`timescale 1ns / 1ps

module thick_line_rasterizer_top_tb;

    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_WAIT  = 8;
    localparam int ITEM_TARGET  = 1050;
    localparam int N_PHASES     = 8;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                               cmd;
        logic signed [tlr_pkg::COORD_W-1:0] sx;
        logic signed [tlr_pkg::COORD_W-1:0] sy;
        logic signed [tlr_pkg::COORD_W-1:0] ex;
        logic signed [tlr_pkg::COORD_W-1:0] ey;
        logic [tlr_pkg::COLOR_W-1:0]        color;
        logic [tlr_pkg::BRUSH_W-1:0]        brush;
    } line_item_t;

    typedef struct packed {
        logic                       wr;
        logic [tlr_pkg::ADDR_W-1:0] addr;
        logic [tlr_pkg::INK_W-1:0]  value;
        logic                       done;
        logic                       idle;
    } pixel_t;

    typedef struct packed {
        line_item_t item;
        logic       typed;
        pixel_t     pix;
    } plan_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic                          cfg_index;
    logic [tlr_pkg::CW_W-1:0]      cfg_data;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [tlr_pkg::S_TDATA_W-1:0] s_axis_tdata;
    logic                          s_axis_tuser;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [tlr_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [tlr_pkg::M_TUSER_W-1:0] m_axis_tuser;
    logic                          m_axis_tlast;

    thick_line_rasterizer_top u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Line engine state as seen by the predictor.
    bit          line_active;
    int          pos_x, pos_y, tgt_x, tgt_y;
    bit          back_x, back_y;
    int          run_x, run_y, err_term;
    int          off_x, off_y, brush_side;
    logic [15:0] ink;
    int          canvas_w, canvas_h;

    pixel_t    pixels_due[$];
    plan_row_t plan[$];

    int gap_pct, stall_pct;
    int fail_count, n_items, n_loads, n_steps;
    int n_pixels, n_written, n_done, n_idle;
    int quiet_cycles;

    int phase_w [N_PHASES] = '{320, 1, 160, 511, 0, 100, 320, 257};
    int phase_h [N_PHASES] = '{116, 1, 58, 127, 0, 116, 1, 73};

    function automatic bit trace_pixel(input line_item_t it, output pixel_t res);
        int  lo, x, y, px, py, twice;
        bit  last_px;
        res = '0;
        if (it.cmd == tlr_pkg::CMD_LOAD)
        begin
            pos_x = int'($signed(it.sx));
            pos_y = int'($signed(it.sy));
            tgt_x = int'($signed(it.ex));
            tgt_y = int'($signed(it.ey));
            back_x = !(pos_x < tgt_x);
            back_y = !(pos_y < tgt_y);
            run_x = tgt_x > pos_x ? tgt_x - pos_x : pos_x - tgt_x;
            run_y = tgt_y > pos_y ? tgt_y - pos_y : pos_y - tgt_y;
            err_term = run_x - run_y;
            // RGB565 keeps the top 5, 6 and 5 bits of red, green and blue.
            ink = {it.color[23:19], it.color[15:10], it.color[7:3]};
            brush_side = int'(it.brush);
            off_x = 0;
            off_y = 0;
            line_active = 1'b1;
            return 1'b0;
        end
        if (!line_active)
        begin
            res.idle = 1'b1;
            return 1'b1;
        end
        res.value = ink;
        if (brush_side > 0)
        begin
            lo = brush_side / 2;
            x = pos_x - lo + off_x;
            y = pos_y - lo + off_y;
            if (x >= 0 && x < tlr_pkg::LOGICAL_WIDTH && y >= 0 && y < tlr_pkg::LOGICAL_HEIGHT)
            begin
                px = x * canvas_w / tlr_pkg::LOGICAL_WIDTH;
                py = y * canvas_h / tlr_pkg::LOGICAL_HEIGHT;
                res.wr = 1'b1;
                res.addr = tlr_pkg::ADDR_W'(py * canvas_w + px);
            end
            last_px = (off_x == brush_side - 1) && (off_y == brush_side - 1);
        end
        else
        begin
            last_px = 1'b1;
        end
        if (!last_px)
        begin
            off_x++;
            if (off_x >= brush_side)
            begin
                off_x = 0;
                off_y++;
            end
        end
        else
        begin
            off_x = 0;
            off_y = 0;
            if (pos_x == tgt_x && pos_y == tgt_y)
            begin
                res.done = 1'b1;
                line_active = 1'b0;
            end
            else
            begin
                twice = 2 * err_term;
                if (twice >= -run_y)
                begin
                    err_term -= run_y;
                    pos_x += back_x ? -1 : 1;
                end
                if (twice <= run_x)
                begin
                    err_term += run_x;
                    pos_y += back_y ? -1 : 1;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic line_item_t load_item(input int sx, input int sy, input int ex,
                                             input int ey,
                                             input logic [tlr_pkg::COLOR_W-1:0] color,
                                             input logic [tlr_pkg::BRUSH_W-1:0] brush);
        line_item_t it;
        it.cmd = tlr_pkg::CMD_LOAD;
        it.sx = tlr_pkg::COORD_W'(sx);
        it.sy = tlr_pkg::COORD_W'(sy);
        it.ex = tlr_pkg::COORD_W'(ex);
        it.ey = tlr_pkg::COORD_W'(ey);
        it.color = color;
        it.brush = brush;
        return it;
    endfunction

    // The load fields of a step item are ignored, so they carry noise.
    function automatic line_item_t step_item();
        line_item_t it;
        it = load_item($urandom, $urandom, $urandom, $urandom,
                       tlr_pkg::COLOR_W'($urandom), tlr_pkg::BRUSH_W'($urandom));
        it.cmd = tlr_pkg::CMD_STEP;
        return it;
    endfunction

    function automatic pixel_t pix_of(input bit wr, input int addr, input int value,
                                      input bit done, input bit idle);
        pixel_t p;
        p.wr = wr;
        p.addr = tlr_pkg::ADDR_W'(addr);
        p.value = tlr_pkg::INK_W'(value);
        p.done = done;
        p.idle = idle;
        return p;
    endfunction

    function automatic plan_row_t plan_of(input line_item_t it, input bit typed,
                                          input pixel_t pix);
        plan_row_t r;
        r.item = it;
        r.typed = typed;
        r.pix = pix;
        return r;
    endfunction

    task automatic send_item(input line_item_t it, input bit typed, input pixel_t typed_pix);
        pixel_t p;
        bit     has;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.cmd;
        s_axis_tdata <= {7'd0, it.brush, it.color, it.ey, it.ex, it.sy, it.sx};
        do @(posedge clk); while (!s_axis_tready);
        has = trace_pixel(it, p);
        if (has)
            pixels_due.push_back(typed ? typed_pix : p);
        n_items++;
        if (it.cmd == tlr_pkg::CMD_LOAD)
            n_loads++;
        else
            n_steps++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        // A load gives no result, so it adds nothing to the queue waited on above.
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic set_canvas(input int w, input int h);
        cfg_we <= 1'b1;
        cfg_index <= tlr_pkg::CFG_CANVAS_WIDTH;
        cfg_data <= tlr_pkg::CW_W'(w);
        @(posedge clk);
        cfg_index <= tlr_pkg::CFG_CANVAS_HEIGHT;
        cfg_data <= tlr_pkg::CW_W'(h & 8'h7F);
        @(posedge clk);
        cfg_we <= 1'b0;
        canvas_w = w & 16'h1FF;
        canvas_h = h & 8'h7F;
    endtask

    // Sends items until the running total reaches the goal.
    task automatic run_phase(input int goal);
        int r, b, reach, sx, sy, ex, ey, ax, ay, n;
        while (n_items < goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                // A complete line near the logical area, stepped to its end.
                b = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(4, 6);
                reach = (b > 3) ? 2 : 6;
                sx = int'($urandom_range(0, tlr_pkg::LOGICAL_WIDTH + 7)) - 4;
                sy = int'($urandom_range(0, tlr_pkg::LOGICAL_HEIGHT + 7)) - 4;
                ex = sx + int'($urandom_range(0, 2 * reach)) - reach;
                ey = sy + int'($urandom_range(0, 2 * reach)) - reach;
                ax = ex > sx ? ex - sx : sx - ex;
                ay = ey > sy ? ey - sy : sy - ey;
                n = ((ax > ay ? ax : ay) + 1) * (b == 0 ? 1 : b * b);
                send_item(load_item(sx, sy, ex, ey, tlr_pkg::COLOR_W'($urandom),
                                    tlr_pkg::BRUSH_W'(b)), 1'b0, '0);
                repeat (n) send_item(step_item(), 1'b0, '0);
                if ($urandom_range(0, 99) < 30)
                    send_item(step_item(), 1'b0, '0);
            end
            else if (r < 85)
            begin
                // Anywhere in the coordinate range, usually dropped by the next load.
                send_item(load_item($urandom, $urandom, $urandom, $urandom,
                                    tlr_pkg::COLOR_W'($urandom),
                                    tlr_pkg::BRUSH_W'($urandom)), 1'b0, '0);
                repeat ($urandom_range(0, 12)) send_item(step_item(), 1'b0, '0);
            end
            else
            begin
                send_item(step_item(), 1'b0, '0);
            end
        end
    endtask

    always @(posedge clk)
    begin : take_pixel
        pixel_t got;
        pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = pix_of(m_axis_tuser[tlr_pkg::TUSER_VALID], int'(m_axis_tdata[15:0]),
                         int'(m_axis_tdata[31:16]), m_axis_tlast,
                         m_axis_tuser[tlr_pkg::TUSER_IDLE]);
            n_pixels++;
            if (got.wr)
                n_written++;
            if (got.done)
                n_done++;
            if (got.idle)
                n_idle++;
            if (pixels_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                begin
                    $display("%0t: pixel with none pending", $realtime);
                    $display("  got  wr=%0b addr=%0d value=%h done=%0b idle=%0b",
                             got.wr, got.addr, got.value, got.done, got.idle);
                end
            end
            else
            begin
                want = pixels_due.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: pixel %0d mismatch", $realtime, n_pixels);
                        $display("  got  wr=%0b addr=%0d value=%h done=%0b idle=%0b",
                                 got.wr, got.addr, got.value, got.done, got.idle);
                        $display("  want wr=%0b addr=%0d value=%h done=%0b idle=%0b",
                                 want.wr, want.addr, want.value, want.done, want.idle);
                    end
                end
            end
        end
    end

    initial
    begin
        m_axis_tready = 1'b1;
        forever
        begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Ends the run if neither side moves an item for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int budget;
        int start;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = tlr_pkg::CFG_CANVAS_WIDTH;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = tlr_pkg::CMD_LOAD;
        quiet_cycles = 0;
        gap_pct = 25;
        stall_pct = 8;
        line_active = 1'b0;
        pos_x = 0;
        pos_y = 0;
        tgt_x = 0;
        tgt_y = 0;
        back_x = 1'b0;
        back_y = 1'b0;
        run_x = 0;
        run_y = 0;
        err_term = 0;
        off_x = 0;
        off_y = 0;
        brush_side = 0;
        ink = '0;
        canvas_w = 320;
        canvas_h = 116;

        // Directed rows run on the reset canvas of 320 x 116.
        plan.push_back(plan_of(step_item(), 1'b1, pix_of(0, 0, 0, 0, 1)));
        plan.push_back(plan_of(load_item(0, 0, 0, 0, 24'hFFFFFF, 1), 1'b0, '0));
        plan.push_back(plan_of(step_item(), 1'b1, pix_of(1, 0, 16'hFFFF, 1, 0)));
        plan.push_back(plan_of(step_item(), 1'b1, pix_of(0, 0, 0, 0, 1)));
        plan.push_back(plan_of(load_item(319, 115, 319, 115, 24'hF80000, 1), 1'b0, '0));
        plan.push_back(plan_of(step_item(), 1'b1, pix_of(1, 37119, 16'hF800, 1, 0)));
        plan.push_back(plan_of(load_item(-1024, -1024, 1023, 1023, 24'h00FC00, 0), 1'b0, '0));
        plan.push_back(plan_of(step_item(), 1'b1, pix_of(0, 0, 16'h07E0, 0, 0)));
        plan.push_back(plan_of(step_item(), 1'b0, '0));
        plan.push_back(plan_of(load_item(1023, -1024, -1024, 1023, 24'h0000F8, 31), 1'b0, '0));
        plan.push_back(plan_of(step_item(), 1'b0, '0));
        plan.push_back(plan_of(step_item(), 1'b0, '0));
        plan.push_back(plan_of(load_item(5, 5, 6, 7, 24'h000000, 0), 1'b0, '0));
        plan.push_back(plan_of(step_item(), 1'b0, '0));
        plan.push_back(plan_of(step_item(), 1'b0, '0));
        plan.push_back(plan_of(step_item(), 1'b1, pix_of(0, 0, 0, 1, 0)));
        plan.push_back(plan_of(load_item(318, 114, 319, 115, 24'h123456, 3), 1'b0, '0));
        plan.push_back(plan_of(step_item(), 1'b0, '0));
        plan.push_back(plan_of(step_item(), 1'b0, '0));
        plan.push_back(plan_of(step_item(), 1'b0, '0));
        // Brush pixels of this point all fall left of and above the area.
        plan.push_back(plan_of(load_item(-1, -1, -1, -1, 24'hFFFFFF, 2), 1'b0, '0));
        repeat (4) plan.push_back(plan_of(step_item(), 1'b0, '0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_item(plan[i].item, plan[i].typed, plan[i].pix);

        start = n_items;
        budget = (ITEM_TARGET - start) / N_PHASES;
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            // One phase runs without idling, and so does the last one.
            if (ph == 2 || ph == N_PHASES - 1)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct = 25;
                stall_pct = 8;
            end
            drain();
            set_canvas(phase_w[ph], phase_h[ph]);
            run_phase(start + (ph + 1) * budget);
        end

        drain();
        repeat (16) @(posedge clk);

        $display("Sent %0d items (%0d loads, %0d steps) on %0d canvas sizes incl. 0x0, 511x127.",
                 n_items, n_loads, n_steps, N_PHASES);
        $display("Checked %0d pixels: %0d written, %0d line ends, %0d idle steps, %0d failures.",
                 n_pixels, n_written, n_done, n_idle, fail_count);
        if (fail_count == 0 && pixels_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tlr_pkg.sv
design/tlr_ctrl.sv
design/tlr_datapath.sv
design/thick_line_rasterizer_top.sv
test/thick_line_rasterizer_top_tb.sv
